// File: sv/rbfc_pkg.sv
// ---------------------------------------------------------------------------
// rbfc_pkg: shared types and constants of the receive ring buffer
// Operation codes, register indexes, reset values, and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package rbfc_pkg;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAIN   = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE    = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 2'd2;

  // configuration reset values
  localparam logic              FRAME_MODE_RST = 1'b1;
  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd64;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd35;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the incoming item
    logic exec;    // perform the latched operation
    logic stream;  // read out the stored run
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;    // output register can take a result this cycle
    logic empty_run;    // latched operation gives a single status result
    logic stream_done;  // last byte of the run leaves the read stage
  } dp_status_t;

endpackage

// File: sv/rbfc_ctrl.sv
// ---------------------------------------------------------------------------
// rbfc_ctrl: operation sequencer
// Accepts one item at a time, waits for a free output slot to execute it,
// then streams the byte run of a drain or take-frame.
// ---------------------------------------------------------------------------
module rbfc_ctrl
  import rbfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // commands
  always_comb begin
    cmd.accept = in_valid && in_ready;
    cmd.exec   = (state_r == ST_EXEC) && sts.slot_free;
    cmd.stream = (state_r == ST_STREAM);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.slot_free) state_nxt = sts.empty_run ? ST_IDLE : ST_STREAM;
      end
      ST_STREAM: begin
        if (sts.stream_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // an item is executed only after being accepted
  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not move to execute");

  // a status-only operation never starts a byte stream
  a_no_stream_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.empty_run) |=> !cmd.stream)
    else $error("stream started for an empty run");

  // streaming ends only when the run is done
  a_stream_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.stream && !sts.stream_done) |=> cmd.stream)
    else $error("stream left early");
`endif

endmodule

// File: sv/rbfc_dp.sv
// ---------------------------------------------------------------------------
// rbfc_dp: ring storage, pointers, frame parser and result register
// Holds the byte ring, the read/write and frame marker pointers, the
// configuration registers and a two-stage read pipeline into the output.
// ---------------------------------------------------------------------------
module rbfc_dp
  import rbfc_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  // item payload
  input  logic [OP_W-1:0]      in_operation,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // control
  input  ctrl_cmd_t            cmd,
  output dp_status_t           sts,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic                 out_frame_pending,
  output logic                 out_data_available,
  output logic                 out_overrun
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W = IDX_W + 1;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // entries from s up to (not including) e, with wrap
  function automatic logic [LEN_W-1:0] ring_dist(input logic [IDX_W-1:0] s,
                                                 input logic [IDX_W-1:0] e);
    logic [LEN_W-1:0] d;
    d = {1'b0, e} - {1'b0, s};
    if (e < s) d = d + LEN_W'(RING_DEPTH);
    return d;
  endfunction

  // configuration
  logic              frame_mode_r;
  logic [BYTE_W-1:0] start_char_r;
  logic [BYTE_W-1:0] end_char_r;

  // latched item
  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] data_r;

  // ring state
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  logic [IDX_W-1:0]  wr_r, wr_nxt;
  logic [IDX_W-1:0]  rd_r, rd_nxt;
  logic [IDX_W-1:0]  open_r, open_nxt;
  logic [IDX_W-1:0]  close_r, close_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              ready_r, ready_nxt;
  logic              ovr;

  // run bookkeeping
  logic [IDX_W-1:0]  take_start;
  logic [LEN_W-1:0]  drain_len;
  logic [LEN_W-1:0]  take_len;
  logic [LEN_W-1:0]  run_len;
  logic [IDX_W-1:0]  run_start;
  logic              empty_run;

  // read pipeline
  logic [LEN_W-1:0]  rem_r;
  logic [IDX_W-1:0]  raddr_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic              rd_last_r;
  logic              slot_free;
  logic              issue;
  logic              rd_move;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_byte_valid_r;
  logic              out_last_r;
  logic              out_pending_r;
  logic              out_avail_r;
  logic              out_ovr_r;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= FRAME_MODE_RST;
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_MODE: frame_mode_r <= cfg_data[0];
        CFG_START_CHAR: start_char_r <= cfg_data;
        CFG_END_CHAR:   end_char_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      data_r <= in_rx_byte;
    end
  end

  // run length and start for drain / take-frame
  always_comb begin
    take_start = wrap_inc(open_r);
    drain_len  = ring_dist(rd_r, wr_r);
    take_len   = ring_dist(take_start, close_r);
    run_len    = '0;
    run_start  = rd_r;
    case (op_r)
      OP_DRAIN: run_len = drain_len;
      OP_TAKE: begin
        run_start = take_start;
        if (ready_r) run_len = take_len;
      end
      default: run_len = '0;
    endcase
    empty_run = (run_len == '0);
  end

  // pointer, parser and flag update
  always_comb begin
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    open_nxt     = open_r;
    close_nxt    = close_r;
    in_frame_nxt = in_frame_r;
    ready_nxt    = ready_r;
    ovr          = 1'b0;
    if (cmd.exec) begin
      unique case (op_r)
        OP_RECEIVE: begin
          wr_nxt = wrap_inc(wr_r);
          // full ring: drop oldest byte, cancel pending frame
          if (wrap_inc(wr_r) == rd_r) begin
            rd_nxt = wrap_inc(rd_r);
            ovr    = 1'b1;
            if (ready_r) begin
              ready_nxt    = 1'b0;
              in_frame_nxt = 1'b0;
            end
          end
          // delimiter parser
          if (frame_mode_r) begin
            if (!in_frame_nxt) begin
              if (data_r == start_char_r) begin
                in_frame_nxt = 1'b1;
                open_nxt     = wr_r;
              end
            end else if (data_r == start_char_r) begin
              open_nxt = wr_r;
            end else if (data_r == end_char_r) begin
              close_nxt = wr_r;
              // end right after start: empty frame, back to waiting
              if (wr_r != wrap_inc(open_r)) ready_nxt = 1'b1;
              else in_frame_nxt = 1'b0;
            end
          end
        end
        OP_DRAIN: begin
          rd_nxt = wr_r;
        end
        OP_TAKE: begin
          if (ready_r) begin
            ready_nxt    = 1'b0;
            in_frame_nxt = 1'b0;
            rd_nxt       = close_r;
          end
        end
        OP_CLEAR: begin
          wr_nxt       = '0;
          rd_nxt       = '0;
          open_nxt     = '0;
          close_nxt    = '0;
          in_frame_nxt = 1'b0;
          ready_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r       <= '0;
      rd_r       <= '0;
      open_r     <= '0;
      close_r    <= '0;
      in_frame_r <= 1'b0;
      ready_r    <= 1'b0;
    end else begin
      wr_r       <= wr_nxt;
      rd_r       <= rd_nxt;
      open_r     <= open_nxt;
      close_r    <= close_nxt;
      in_frame_r <= in_frame_nxt;
      ready_r    <= ready_nxt;
    end
  end

  // read pipeline handshake
  assign slot_free = !out_valid_r || out_ready;
  assign rd_move   = rd_vld_r && slot_free;
  assign issue     = cmd.stream && (rem_r != '0) && (!rd_vld_r || slot_free);

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == OP_RECEIVE)) ring_mem[wr_r] <= data_r;
    if (issue) rd_data_r <= ring_mem[raddr_r];
  end

  // run counter and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.exec && !empty_run) begin
        rem_r <= run_len;
      end else if (issue) begin
        rem_r <= rem_r - 1'b1;
      end
      if (issue) rd_vld_r <= 1'b1;
      else if (rd_move) rd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !empty_run) begin
      raddr_r <= run_start;
    end else if (issue) begin
      raddr_r <= wrap_inc(raddr_r);
    end
    if (issue) rd_last_r <= (rem_r == LEN_W'(1));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec && empty_run) begin
      out_valid_r <= 1'b1;
    end else if (rd_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && empty_run) begin
      out_byte_r       <= '0;
      out_byte_valid_r <= 1'b0;
      out_last_r       <= 1'b1;
      out_pending_r    <= ready_nxt;
      out_avail_r      <= (rd_nxt != wr_nxt);
      out_ovr_r        <= ovr;
    end else if (rd_move) begin
      out_byte_r       <= rd_data_r;
      out_byte_valid_r <= 1'b1;
      out_last_r       <= rd_last_r;
      out_pending_r    <= ready_r;
      out_avail_r      <= (rd_r != wr_r);
      out_ovr_r        <= 1'b0;
    end
  end

  always_comb begin
    sts.slot_free   = slot_free;
    sts.empty_run   = empty_run;
    sts.stream_done = (rem_r == '0) && (!rd_vld_r || slot_free);
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_byte_valid     = out_byte_valid_r;
  assign out_last           = out_last_r;
  assign out_frame_pending  = out_pending_r;
  assign out_data_available = out_avail_r;
  assign out_overrun        = out_ovr_r;

`ifndef NO_ASSERTIONS
  // taking a pending frame always clears it
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op_r == OP_TAKE) && ready_r) |=> !ready_r)
    else $error("pending frame survived take");

  // after a receive there is always unread data
  a_receive_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op_r == OP_RECEIVE)) |=> (rd_r != wr_r))
    else $error("ring empty after receive");

  // a stalled read stage keeps its byte
  a_rd_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && !slot_free) |=> (rd_vld_r && $stable(rd_data_r)))
    else $error("read stage lost its byte under stall");

  // bytes are read only while streaming
  a_issue_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (cmd.stream && !cmd.exec))
    else $error("memory read outside the stream");
`endif

endmodule

// File: sv/rx_ring_buffer_frame_capture_top.sv
// Receive and clear give their result through the output register after the
//   accept and execute steps; a new item is taken only once the last is done.
// Drain and take-frame: after the accept and execute steps, one byte per cycle
//   through the registered memory read port while the output is not stalled.
// Reset (synchronous, active low) clears pointers, parser, flags and restores
//   the register defaults; ring contents are not cleared and need no sweep.
// ---------------------------------------------------------------------------
// rx_ring_buffer_frame_capture_top: receive ring buffer with frame capture
// Stores received bytes in a ring, marks delimited frames, and reads out
// a pending frame or all unread bytes one item at a time.
// ---------------------------------------------------------------------------
module rx_ring_buffer_frame_capture_top
  import rbfc_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic                 out_frame_pending,
  output logic                 out_data_available,
  output logic                 out_overrun
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer
  rbfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  rbfc_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_operation       (in_operation),
    .in_rx_byte         (in_rx_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_frame_pending  (out_frame_pending),
    .out_data_available (out_data_available),
    .out_overrun        (out_overrun)
  );

endmodule

// File: test/tb_rx_ring_buffer_frame_capture_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rx_ring_buffer_frame_capture_top: self-checking bench for the rx ring
// Runs a short table of directed items, then phases of random frames,
// noise, floods and drains under different delimiter settings. Every result
// item is checked field by field against a cycle-free model of the ring.
// ---------------------------------------------------------------------------
module tb_rx_ring_buffer_frame_capture_top;
  import rbfc_pkg::*;

  localparam int DEPTH          = 64;
  localparam int IDX_W          = $clog2(DEPTH);
  localparam int RANDOM_ITEMS   = 250;
  localparam int PHASE_ITEMS    = 35;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;

  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              byte_valid;
    logic              is_last;
    logic              pending;
    logic              avail;
    logic              overrun;
  } result_t;

  // directed step: an item, or a register write when is_cfg is set
  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        code;
    logic [BYTE_W-1:0] data;
    logic              typed;
    result_t           res;
  } dir_row_t;

  // status-only results that read off at a glance
  localparam result_t ST_EMPTY = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam result_t ST_DATA  = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam result_t ST_FRAME = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  localparam int DIR_ROWS = 35;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty ring: take and drain give a bare status item
    '{1'b0, OP_TAKE,    8'h00, 1'b1, ST_EMPTY},
    '{1'b0, OP_DRAIN,   8'hFF, 1'b1, ST_EMPTY},
    // byte extremes
    '{1'b0, OP_RECEIVE, 8'h00, 1'b1, ST_DATA},
    '{1'b0, OP_RECEIVE, 8'hFF, 1'b1, ST_DATA},
    // end right after start: no frame
    '{1'b0, OP_RECEIVE, START_CHAR_RST, 1'b1, ST_DATA},
    '{1'b0, OP_RECEIVE, END_CHAR_RST,   1'b1, ST_DATA},
    // repeated start moves the open marker, then a real frame
    '{1'b0, OP_RECEIVE, START_CHAR_RST, 1'b0, '0},
    '{1'b0, OP_RECEIVE, START_CHAR_RST, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h55, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'hAA, 1'b0, '0},
    '{1'b0, OP_RECEIVE, END_CHAR_RST,   1'b1, ST_FRAME},
    // bytes after a ready frame; a second end moves the close marker
    '{1'b0, OP_RECEIVE, 8'h11, 1'b0, '0},
    '{1'b0, OP_RECEIVE, END_CHAR_RST,   1'b0, '0},
    '{1'b0, OP_TAKE,    8'hA5, 1'b0, '0},
    '{1'b0, OP_DRAIN,   8'h5A, 1'b0, '0},
    '{1'b0, OP_CLEAR,   8'hC3, 1'b1, ST_EMPTY},
    '{1'b0, OP_DRAIN,   8'h3C, 1'b1, ST_EMPTY},
    // extreme delimiters
    '{1'b1, CFG_START_CHAR, 8'hFF, 1'b0, '0},
    '{1'b1, CFG_END_CHAR,   8'h00, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'hFF, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h00, 1'b1, ST_DATA},
    // equal delimiters count as start
    '{1'b1, CFG_START_CHAR, 8'h2A, 1'b0, '0},
    '{1'b1, CFG_END_CHAR,   8'h2A, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h2A, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h41, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h2A, 1'b1, ST_DATA},
    '{1'b0, OP_DRAIN,   8'h00, 1'b0, '0},
    // parsing off, upper data bits ignored; spare index ignored
    '{1'b1, CFG_FRAME_MODE, 8'hFE, 1'b0, '0},
    '{1'b1, CFG_SPARE_IDX,  8'h77, 1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h2A, 1'b0, '0},
    '{1'b0, OP_TAKE,    8'h00, 1'b0, '0},
    // back to defaults
    '{1'b1, CFG_FRAME_MODE, 8'h01, 1'b0, '0},
    '{1'b1, CFG_START_CHAR, START_CHAR_RST, 1'b0, '0},
    '{1'b1, CFG_END_CHAR,   END_CHAR_RST,   1'b0, '0},
    '{1'b0, OP_RECEIVE, 8'h80, 1'b0, '0}
  };

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [BYTE_W-1:0]    in_rx_byte   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_byte_valid;
  logic                 out_last;
  logic                 out_frame_pending;
  logic                 out_data_available;
  logic                 out_overrun;

  // ring model state
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  bit                written  [DEPTH];
  logic [IDX_W-1:0]  wr_ptr, rd_ptr, open_ptr, close_ptr;
  logic              in_frame, frm_pend;
  logic              mode_q;
  logic [BYTE_W-1:0] start_q, end_q;

  result_t owed_results [$];
  int      fail_count   = 0;
  int      items_sent   = 0;
  int      quiet_cycles = 0;
  int      burst_left   = 0;
  bit      gaps_on      = 1'b1;
  bit      rcv_steady   = 1'b0;
  int      ready_run    = 0;
  int      stall_run    = 0;

  rx_ring_buffer_frame_capture_top #(.RING_DEPTH(DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_byte_valid     (out_byte_valid),
    .out_last           (out_last),
    .out_frame_pending  (out_frame_pending),
    .out_data_available (out_data_available),
    .out_overrun        (out_overrun)
  );

  always #6 clk = ~clk;

  function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // payload byte that is neither delimiter
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == start_q || b == end_q);
    return b;
  endfunction

  // advance the ring model by one item and queue the results it owes
  function automatic void predict_ring_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                          logic typed, result_t typed_res);
    logic [BYTE_W-1:0] run_bytes [$];
    logic [IDX_W-1:0]  pos, idx;
    logic              ovr;
    result_t           res;
    ovr = 1'b0;
    case (op)
      OP_RECEIVE: begin
        pos = wr_ptr;
        ring_mem[pos] = data;
        written[pos]  = 1'b1;
        // full ring: drop oldest, cancel a pending frame
        if (ring_next(pos) == rd_ptr) begin
          rd_ptr = ring_next(rd_ptr);
          ovr    = 1'b1;
          if (frm_pend) begin
            frm_pend = 1'b0;
            in_frame = 1'b0;
          end
        end
        wr_ptr = ring_next(pos);
        if (mode_q) begin
          if (!in_frame) begin
            if (data == start_q) begin
              in_frame = 1'b1;
              open_ptr = pos;
            end
          end else if (data == start_q) begin
            open_ptr = pos;
          end else if (data == end_q) begin
            close_ptr = pos;
            if (pos != ring_next(open_ptr)) frm_pend = 1'b1;
            else in_frame = 1'b0;
          end
        end
      end
      OP_DRAIN: begin
        idx = rd_ptr;
        while (idx != wr_ptr) begin
          run_bytes.push_back(ring_mem[idx]);
          idx = ring_next(idx);
        end
        rd_ptr = wr_ptr;
      end
      OP_TAKE: begin
        if (frm_pend) begin
          idx = ring_next(open_ptr);
          while (idx != close_ptr) begin
            run_bytes.push_back(ring_mem[idx]);
            idx = ring_next(idx);
          end
          frm_pend = 1'b0;
          in_frame = 1'b0;
          rd_ptr   = close_ptr;
        end
      end
      OP_CLEAR: begin
        wr_ptr    = '0;
        rd_ptr    = '0;
        open_ptr  = '0;
        close_ptr = '0;
        in_frame  = 1'b0;
        frm_pend  = 1'b0;
      end
    endcase
    if (typed) begin
      owed_results.push_back(typed_res);
    end else if (run_bytes.size() == 0) begin
      res = '{8'h00, 1'b0, 1'b1, frm_pend, rd_ptr != wr_ptr, ovr};
      owed_results.push_back(res);
    end else begin
      foreach (run_bytes[k]) begin
        res = '{run_bytes[k], 1'b1, k == run_bytes.size() - 1, frm_pend,
                rd_ptr != wr_ptr, 1'b0};
        owed_results.push_back(res);
      end
    end
  endfunction

  // send one item in bursts with random gaps; predict on acceptance
  task automatic push_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                           logic typed = 1'b0, result_t typed_res = '0);
    int               gap;
    logic [IDX_W-1:0] idx;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    // a take whose range holds never-written entries becomes a drain
    if (op == OP_TAKE && frm_pend) begin
      idx = ring_next(open_ptr);
      while (idx != close_ptr) begin
        if (!written[idx]) op = OP_DRAIN;
        idx = ring_next(idx);
      end
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= data;
    do @(posedge clk); while (!in_ready);
    predict_ring_op(op, data, typed, typed_res);
    items_sent++;
  endtask

  // hold the sender until every owed result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // register write; caller lowers cfg_we after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FRAME_MODE: mode_q  = val[0];
      CFG_START_CHAR: start_q = val;
      CFG_END_CHAR:   end_q   = val;
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result item with none expected, expected none got byte %h",
                 $time, out_byte);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("out_byte", want.byte_val, out_byte);
        check_field("out_byte_valid", BYTE_W'(want.byte_valid), BYTE_W'(out_byte_valid));
        check_field("out_last", BYTE_W'(want.is_last), BYTE_W'(out_last));
        check_field("out_frame_pending", BYTE_W'(want.pending),
                    BYTE_W'(out_frame_pending));
        check_field("out_data_available", BYTE_W'(want.avail),
                    BYTE_W'(out_data_available));
        check_field("out_overrun", BYTE_W'(want.overrun), BYTE_W'(out_overrun));
      end
    end
  end

  // receiver: ready runs and stall runs, or steady ready
  always @(posedge clk) begin
    if (rcv_steady) begin
      out_ready <= 1'b1;
    end else if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run <= ready_run - 1;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run <= stall_run - 1;
    end else begin
      out_ready <= 1'b1;
      ready_run <= $urandom_range(1, 8);
      stall_run <= $urandom_range(0, 5);
    end
  end

  // watchdog: cycles without any handshake or register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_rx_ring_buffer_frame_capture_top: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    int                phase;
    int                phase_start;
    int                base_items;
    int                kind;
    logic [BYTE_W-1:0] mv, sc, ec;
    bit                cfg_open;

    wr_ptr    = '0;
    rd_ptr    = '0;
    open_ptr  = '0;
    close_ptr = '0;
    in_frame  = 1'b0;
    frm_pend  = 1'b0;
    mode_q    = FRAME_MODE_RST;
    start_q   = START_CHAR_RST;
    end_q     = END_CHAR_RST;
    foreach (written[i]) written[i] = 1'b0;
    cfg_open = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(DIRECTED[r].code, DIRECTED[r].data);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        push_item(DIRECTED[r].code, DIRECTED[r].data, DIRECTED[r].typed, DIRECTED[r].res);
      end
    end

    // random phases, each starting with its own register writes
    base_items = items_sent;
    phase      = 0;
    while (items_sent - base_items < RANDOM_ITEMS) begin
      case (phase)
        0, 1: begin
          mv = 8'h01;
          sc = START_CHAR_RST;
          ec = END_CHAR_RST;
        end
        2: begin
          mv = 8'h01;
          sc = 8'h00;
          ec = 8'hFF;
        end
        3: begin
          mv = 8'hFF;
          sc = 8'hFF;
          ec = 8'h00;
        end
        4: begin
          mv = BYTE_W'($urandom) & 8'hFE;
          sc = BYTE_W'($urandom);
          ec = sc ^ 8'h01;
        end
        5: begin
          mv = BYTE_W'($urandom) | 8'h01;
          sc = BYTE_W'($urandom);
          ec = sc;
        end
        default: begin
          mv = BYTE_W'($urandom);
          if ($urandom_range(0, 3) != 0) mv[0] = 1'b1;
          sc = BYTE_W'($urandom);
          ec = BYTE_W'($urandom);
          if (ec == sc) ec = ~sc;
        end
      endcase
      gaps_on    = (phase % 3 != 2);
      rcv_steady = (phase % 3 == 2);

      wait_idle();
      write_reg(CFG_SPARE_IDX, BYTE_W'($urandom));
      write_reg(CFG_FRAME_MODE, mv);
      write_reg(CFG_START_CHAR, sc);
      write_reg(CFG_END_CHAR, ec);
      cfg_we <= 1'b0;

      if (phase == 1) begin
        // pending frame whose open marker moves onto the entry before the
        // close marker after the ring wraps: take gives an empty range
        push_item(OP_CLEAR, BYTE_W'($urandom));
        push_item(OP_RECEIVE, start_q);
        push_item(OP_RECEIVE, plain_byte());
        push_item(OP_RECEIVE, end_q);
        push_item(OP_DRAIN, BYTE_W'($urandom));
        repeat (DEPTH - 2) push_item(OP_RECEIVE, plain_byte());
        push_item(OP_RECEIVE, start_q);
        push_item(OP_TAKE, BYTE_W'($urandom));
      end else begin
        phase_start = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS) begin
          kind = $urandom_range(0, 99);
          if (kind < 45) begin
            // well-formed frame, mostly followed by a take
            push_item(OP_RECEIVE, start_q);
            repeat ($urandom_range(0, 8))
              push_item(OP_RECEIVE,
                        ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : plain_byte());
            push_item(OP_RECEIVE, end_q);
            if ($urandom_range(0, 9) < 6) push_item(OP_TAKE, BYTE_W'($urandom));
          end else if (kind < 70) begin
            repeat ($urandom_range(1, 4)) push_item(OP_W'($urandom), BYTE_W'($urandom));
          end else if (kind < 80) begin
            push_item(OP_DRAIN, BYTE_W'($urandom));
          end else if (kind < 88) begin
            // broken frames
            case ($urandom_range(0, 2))
              0: begin
                push_item(OP_RECEIVE, start_q);
                repeat ($urandom_range(1, 5)) push_item(OP_RECEIVE, plain_byte());
              end
              1: push_item(OP_RECEIVE, end_q);
              default: begin
                push_item(OP_RECEIVE, start_q);
                push_item(OP_RECEIVE, end_q);
              end
            endcase
          end else if (kind < 93) begin
            // flood that can run past the ring size
            repeat ($urandom_range(20, 70)) push_item(OP_RECEIVE, BYTE_W'($urandom));
          end else if (kind < 96) begin
            push_item(OP_CLEAR, BYTE_W'($urandom));
          end else begin
            wait_idle();
          end
        end
      end
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_rx_ring_buffer_frame_capture_top: PASS");
    else $display("tb_rx_ring_buffer_frame_capture_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/rbfc_pkg.sv
sv/rbfc_ctrl.sv
sv/rbfc_dp.sv
sv/rx_ring_buffer_frame_capture_top.sv
test/tb_rx_ring_buffer_frame_capture_top.sv
